FILE: rtl/hdtf_pkg.sv
`default_nettype none

package hdtf_pkg;

  // Window geometry, in frame byte positions
  localparam int unsigned WinLen     = 17;
  localparam int unsigned HistLen    = WinLen - 1;
  localparam int unsigned TailPos    = 16;
  localparam int unsigned LenPos     = 3;
  localparam int unsigned IdHiPos    = 6;
  localparam int unsigned IdLoPos    = 7;
  localparam int unsigned PayloadPos = 8;
  localparam int unsigned PayloadLen = 8;

  localparam int unsigned FillW      = $clog2(WinLen);
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] HeadReset = 8'd170;
  localparam logic [7:0] TailReset = 8'd85;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeadByte = 8'd0,
    CfgTailByte = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  length_code;
    logic [15:0] frame_id;
    logic [63:0] payload;
  } frame_t;

endpackage

`default_nettype wire

FILE: rtl/hdtf_front.sv
`default_nettype none

module hdtf_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [hdtf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [7:0]                    cfg_data_i,
  input  wire                          rx_valid_i,
  output logic                         rx_stall_o,
  input  wire [7:0]                    rx_byte_i,
  input  wire                          q_full_i,
  output logic                         push_o,
  output hdtf_pkg::frame_t             frame_o
);
  import hdtf_pkg::*;

  localparam logic [FillW-1:0] FillFull = FillW'(HistLen);

  logic [7:0]       head_q, head_d;
  logic [7:0]       tail_q, tail_d;
  logic [7:0]       win_q [HistLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign rx_stall_o  = q_full_i;
  assign accept      = rx_valid_i && !rx_stall_o;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgHeadByte: head_d = cfg_data_i;
        CfgTailByte: tail_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // win_q holds the last 16 bytes, oldest at index 0; the incoming byte is frame byte 16
  assign push_o = accept && (fill_q == FillFull) && (win_q[0] == head_q)
                  && (rx_byte_i == tail_q);

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      priority if (push_o) begin
        fill_d = '0;
      end else if (fill_q == FillFull) begin
        fill_d = FillFull;
      end else begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_comb begin
    frame_o.length_code = win_q[LenPos];
    frame_o.frame_id    = {win_q[IdHiPos], win_q[IdLoPos]};
    for (int i = 0; i < PayloadLen; i++) begin
      frame_o.payload[8*i +: 8] = win_q[PayloadPos + i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HeadReset;
      tail_q <= TailReset;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < HistLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[HistLen-1] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hdtf_queue.sv
`default_nettype none

module hdtf_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire hdtf_pkg::frame_t data_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  valid_o,
  output hdtf_pkg::frame_t      data_o
);
  import hdtf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  frame_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hdtf_back.sv
`default_nettype none

module hdtf_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  input  wire hdtf_pkg::frame_t q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [7:0]            length_code_o,
  output logic [15:0]           frame_id_o,
  output logic [63:0]           payload_o,
  output logic [31:0]           sequence_number_o
);
  import hdtf_pkg::*;

  logic        out_valid_q, out_valid_d;
  logic [31:0] seq_q, seq_d;
  frame_t      frame_q;

  // take the next frame when the output register is empty or being drained
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    seq_d       = seq_q;
    priority if (pop_o) begin
      out_valid_d = 1'b1;
      seq_d       = seq_q + 32'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seq_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      seq_q       <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_q <= q_data_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign length_code_o     = frame_q.length_code;
  assign frame_id_o        = frame_q.frame_id;
  assign payload_o         = frame_q.payload;
  assign sequence_number_o = seq_q;

endmodule

`default_nettype wire

FILE: rtl/head_tail_frame_deframer.sv
`default_nettype none

// Fixed-length head/tail deframer. Takes one received byte per cycle while
// rx_stall_o is low and keeps the last 16 bytes; when the oldest equals
// head_byte (register 0) and the incoming byte equals tail_byte (register 1)
// it emits one frame and restarts the window, otherwise it slides by one byte.
// One byte is accepted every cycle unless rx_stall_o is high, with the window
// shift and the two byte compares done as it is taken. Frames wait in a
// two-entry queue ahead of the output register, and rx_stall_o rises only when
// that queue is full because the output side has held off. sequence_number_o
// counts frames from 1 and wraps at 2^32. Configuration writes are always
// ready and take effect on the next byte.
module head_tail_frame_deframer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [hdtf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [7:0]                    cfg_data_i,
  input  wire                          rx_valid_i,
  output logic                         rx_stall_o,
  input  wire [7:0]                    rx_byte_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [7:0]                   length_code_o,
  output logic [15:0]                  frame_id_o,
  output logic [63:0]                  payload_o,
  output logic [31:0]                  sequence_number_o
);
  import hdtf_pkg::*;

  frame_t front_frame, q_frame;
  logic   q_full, q_valid, push, pop;

  hdtf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .frame_o     (front_frame)
  );

  hdtf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_frame),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_frame)
  );

  hdtf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_data_i          (q_frame),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .length_code_o     (length_code_o),
    .frame_id_o        (frame_id_o),
    .payload_o         (payload_o),
    .sequence_number_o (sequence_number_o)
  );

endmodule

`default_nettype wire

FILE: rtl/hdtf_checker.sv
`default_nettype none

module hdtf_checker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  input  wire                          cfg_ready_o,
  input  wire                          rx_stall_o,
  input  wire                          out_valid_o,
  input  wire                          out_stall_i,
  input  wire [7:0]                    length_code_o,
  input  wire [15:0]                   frame_id_o,
  input  wire [63:0]                   payload_o,
  input  wire [31:0]                   sequence_number_o
);

  logic [31:0] last_seq_q;

  // sequence number of the last delivered transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seq_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      last_seq_q <= sequence_number_o;
    end
  end

  // frames are numbered consecutively from one, none skipped or repeated
  a_seq_consecutive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sequence_number_o == last_seq_q + 32'd1))
    else $error("sequence number not one past the last delivered frame");

  // input back-pressure only builds up behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rx_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // configuration channel never holds off a write
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not accepted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(length_code_o)
      && $stable(frame_id_o) && $stable(payload_o) && $stable(sequence_number_o)))
    else $error("stalled output transaction changed");

endmodule

bind head_tail_frame_deframer hdtf_checker u_hdtf_checker (.*);

`default_nettype wire
